@@ rtl/bdlpr_pkg.sv @@
`default_nettype none

package bdlpr_pkg;

  // Field and register widths
  localparam int unsigned HOLD_W         = 16;
  localparam int unsigned CFG_DATA_W     = 16;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned COUNT_WIDTH_DEF = 16;
  localparam int unsigned KEY_STATE_W    = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESSED_LEVEL = 2'd2;

  // Request kinds
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_POLL = 1'b1;

  // Repeat modes
  localparam logic MODE_REPEAT_AFTER_HOLD = 1'b0;
  localparam logic MODE_LONG_PRESS        = 1'b1;

  // Reset values of the configuration registers
  localparam logic              RST_REPEAT_MODE   = MODE_LONG_PRESS;
  localparam logic [HOLD_W-1:0] RST_HOLD_TICKS    = 16'd100;
  localparam logic              RST_PRESSED_LEVEL = 1'b0;

  typedef struct packed {
    logic req_type;
    logic pin_level;
  } req_t;

  typedef struct packed {
    logic                   pressed;
    logic [KEY_STATE_W-1:0] key_state;
  } rsp_t;

  typedef struct packed {
    logic              repeat_mode;
    logic [HOLD_W-1:0] hold_ticks;
    logic              pressed_level;
  } cfg_t;

endpackage

`default_nettype wire

@@ rtl/bdlpr_cfg.sv @@
`default_nettype none

module bdlpr_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_wr_en,
  input  wire logic [bdlpr_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [bdlpr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output bdlpr_pkg::cfg_t                       cfg
);
  import bdlpr_pkg::*;

  cfg_t regs;

  // Decode the write and hold the register values
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.repeat_mode   <= RST_REPEAT_MODE;
      regs.hold_ticks    <= RST_HOLD_TICKS;
      regs.pressed_level <= RST_PRESSED_LEVEL;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_REPEAT_MODE:   regs.repeat_mode   <= cfg_wdata[0];
        REG_HOLD_TICKS:    regs.hold_ticks    <= cfg_wdata[HOLD_W-1:0];
        REG_PRESSED_LEVEL: regs.pressed_level <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

@@ rtl/bdlpr_core.sv @@
`default_nettype none

module bdlpr_core #(
  parameter int unsigned COUNT_WIDTH = bdlpr_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire bdlpr_pkg::cfg_t cfg,
  input  wire logic           accept,
  input  wire bdlpr_pkg::req_t req,
  output bdlpr_pkg::rsp_t     rsp
);
  import bdlpr_pkg::*;

  typedef enum logic [KEY_STATE_W-1:0] {
    ST_IDLE   = 2'd0,
    ST_HELD   = 2'd1,
    ST_REPEAT = 2'd2
  } key_fsm_t;

  key_fsm_t               key_fsm, key_fsm_next;
  logic [2:0]             history, history_next;
  logic [COUNT_WIDTH-1:0] hold_counter, hold_counter_next;
  logic                   press_flag, press_flag_next;
  logic [COUNT_WIDTH-1:0] load_val;
  logic [COUNT_WIDTH-1:0] count_dec;
  logic                   timeout;
  logic                   is_pressed;
  logic                   stable_press;

  // Fit the hold count to the counter width
  generate
    if (COUNT_WIDTH > HOLD_W) begin : g_ext
      assign load_val = {{(COUNT_WIDTH-HOLD_W){1'b0}}, cfg.hold_ticks};
    end else if (COUNT_WIDTH == HOLD_W) begin : g_same
      assign load_val = cfg.hold_ticks;
    end else begin : g_trunc
      assign load_val = cfg.hold_ticks[COUNT_WIDTH-1:0];
    end
  endgenerate

  // Step the counter towards zero and flag the timeout
  assign count_dec  = (hold_counter != '0) ? hold_counter - 1'b1 : '0;
  assign timeout    = (count_dec == '0);
  assign is_pressed = (req.pin_level == cfg.pressed_level);
  // Three equal samples after the shift: the two newest held ones and the pin
  assign stable_press = (history[1] == history[2]) && (history[2] == req.pin_level)
                        && is_pressed;

  // Work out the next state for one request
  always_comb begin
    key_fsm_next      = key_fsm;
    history_next      = history;
    hold_counter_next = hold_counter;
    press_flag_next   = press_flag;
    rsp.pressed       = 1'b0;

    if (req.req_type == REQ_POLL) begin
      rsp.pressed     = press_flag;
      press_flag_next = 1'b0;
    end else begin
      history_next      = {req.pin_level, history[2:1]};
      hold_counter_next = count_dec;
      unique case (key_fsm)
        ST_IDLE: begin
          if (stable_press) begin
            press_flag_next   = 1'b1;
            hold_counter_next = load_val;
            key_fsm_next      = ST_HELD;
          end
        end
        ST_HELD: begin
          if (cfg.repeat_mode == MODE_REPEAT_AFTER_HOLD) begin
            if (timeout) key_fsm_next = ST_IDLE;
          end else if (!is_pressed) begin
            key_fsm_next = ST_IDLE;
          end else if (timeout) begin
            key_fsm_next = ST_REPEAT;
          end
        end
        default: begin
          if (cfg.repeat_mode == MODE_REPEAT_AFTER_HOLD) begin
            if (timeout) key_fsm_next = ST_IDLE;
          end else begin
            press_flag_next = 1'b1;
            if (!is_pressed) key_fsm_next = ST_IDLE;
          end
        end
      endcase
    end
    rsp.key_state = key_fsm_next;
  end

  // Hold the key state; advance only on an accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      key_fsm      <= ST_IDLE;
      history      <= 3'b111;
      hold_counter <= '0;
      press_flag   <= 1'b0;
    end else if (accept) begin
      key_fsm      <= key_fsm_next;
      history      <= history_next;
      hold_counter <= hold_counter_next;
      press_flag   <= press_flag_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/bdlpr_oreg.sv @@
`default_nettype none

module bdlpr_oreg (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            load,
  input  wire bdlpr_pkg::rsp_t rsp,
  output logic                 free,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output bdlpr_pkg::rsp_t      out_data
);
  import bdlpr_pkg::*;

  // Room for a new result when empty or when the held one leaves this cycle
  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  // Capture the result; hold it while the receiver stalls
  always_ff @(posedge clk) begin
    if (load && free) begin
      out_data <= rsp;
    end
  end

endmodule

`default_nettype wire

@@ rtl/button_debounce_long_press_repeat.sv @@
// Push-button qualifier with long-press repeat.
// Input channel (in_valid/in_ready/in_data): each request is either a tick
// carrying the sampled pin level, or a poll that reads and clears the press
// flag. Output channel (out_valid/out_ready/out_data): one result per request,
// with the flag value (polls only) and the key state after the request.
// Configuration: cfg_wr_en/cfg_addr/cfg_wdata write repeat mode, hold count
// and pressed level, one per write, with no read-back; write only while idle.
// Result: registered; it appears in the cycle after the request is accepted.
// Throughput: one request per cycle while results are taken; the state
// update is a single pass of logic ahead of one result register.
// Stall: while a result waits and out_ready is low, in_ready drops and the
// result is held; in_ready stays high whenever the result is taken.
// Reset: configuration returns to mode 1, hold count 100, pressed level 0;
// the key is idle, the sample history reads released, the hold counter is
// timed out, the press flag is clear and no result is pending.
`default_nettype none

module button_debounce_long_press_repeat #(
  parameter int unsigned COUNT_WIDTH = bdlpr_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_wr_en,
  input  wire logic [bdlpr_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [bdlpr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire bdlpr_pkg::req_t                  in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output bdlpr_pkg::rsp_t                       out_data
);
  import bdlpr_pkg::*;

  cfg_t cfg;
  rsp_t rsp;
  logic accept;

  assign accept = in_valid && in_ready;

  bdlpr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bdlpr_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .accept (accept),
    .req    (in_data),
    .rsp    (rsp)
  );

  bdlpr_oreg u_oreg (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .rsp       (rsp),
    .free      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ sim/bdlpr_checker.sv @@
`default_nettype none

module bdlpr_checker (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_wr_en,
  input  wire logic [bdlpr_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [bdlpr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                             in_valid,
  input  wire logic                             in_ready,
  input  wire bdlpr_pkg::req_t                  in_data,
  input  wire logic                             out_valid,
  input  wire logic                             out_ready,
  input  wire bdlpr_pkg::rsp_t                  out_data,
  output int                                    mismatch_count,
  output int                                    results_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import bdlpr_pkg::*;

  localparam logic [KEY_STATE_W-1:0] KEY_IDLE   = 2'd0;
  localparam logic [KEY_STATE_W-1:0] KEY_HELD   = 2'd1;
  localparam logic [KEY_STATE_W-1:0] KEY_REPEAT = 2'd2;

  // Shadow copy of the configuration registers
  logic              mode_q;
  logic [HOLD_W-1:0] hold_q;
  logic              level_q;

  // Shadow key state; history[2] is the newest sample
  logic [2:0]                   history;
  logic [KEY_STATE_W-1:0]       key_state;
  logic [COUNT_WIDTH_DEF-1:0]   hold_count;
  logic                         press_flag;

  rsp_t expected_q[$];
  int   errors;
  int   outstanding;

  assign mismatch_count      = errors;
  assign results_outstanding = outstanding;

  // Advance the key model by one request and return the result it gives
  function automatic rsp_t qualify_request(req_t r);
    rsp_t res;
    logic timed_out;
    logic at_press;
    res.pressed = 1'b0;
    if (r.req_type == REQ_POLL) begin
      res.pressed = press_flag;
      press_flag  = 1'b0;
    end else begin
      history = {r.pin_level, history[2:1]};
      if (hold_count != '0) begin
        hold_count = hold_count - 1'b1;
      end
      timed_out = (hold_count == '0);
      at_press  = (r.pin_level == level_q);
      case (key_state)
        KEY_IDLE: begin
          if ((history == 3'b000 || history == 3'b111) && at_press) begin
            press_flag = 1'b1;
            hold_count = hold_q[COUNT_WIDTH_DEF-1:0];
            key_state  = KEY_HELD;
          end
        end
        default: begin
          if (mode_q == MODE_REPEAT_AFTER_HOLD) begin
            // held and repeat behave alike here: leave on timeout
            if (timed_out) begin
              key_state = KEY_IDLE;
            end
          end else if (key_state == KEY_HELD) begin
            if (!at_press) begin
              key_state = KEY_IDLE;
            end else if (timed_out) begin
              key_state = KEY_REPEAT;
            end
          end else begin
            // repeat flags every tick, the release tick included
            press_flag = 1'b1;
            if (!at_press) begin
              key_state = KEY_IDLE;
            end
          end
        end
      endcase
    end
    res.key_state = key_state;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    rsp_t want;
    if (rst) begin
      mode_q     = RST_REPEAT_MODE;
      hold_q     = RST_HOLD_TICKS;
      level_q    = RST_PRESSED_LEVEL;
      history    = 3'b111;
      key_state  = KEY_IDLE;
      hold_count = '0;
      press_flag = 1'b0;
      errors     = 0;
      expected_q.delete();
    end else begin
      // Track register writes
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_REPEAT_MODE:   mode_q  = cfg_wdata[0];
          REG_HOLD_TICKS:    hold_q  = cfg_wdata[HOLD_W-1:0];
          REG_PRESSED_LEVEL: level_q = cfg_wdata[0];
          default: ;
        endcase
      end
      // Compare each result with the oldest expectation
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got pressed %0b state %0d",
                   $time, out_data.pressed, out_data.key_state);
        end else begin
          want = expected_q.pop_front();
          if (out_data.pressed !== want.pressed) begin
            errors++;
            $display("%0t: pressed mismatch, expected %0b, got %0b",
                     $time, want.pressed, out_data.pressed);
          end
          if (out_data.key_state !== want.key_state) begin
            errors++;
            $display("%0t: key_state mismatch, expected %0d, got %0d",
                     $time, want.key_state, out_data.key_state);
          end
        end
      end
      // Predict each accepted request
      if (in_valid && in_ready) begin
        expected_q.push_back(qualify_request(in_data));
      end
    end
    outstanding = expected_q.size();
  end

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bdlpr_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 110;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  req_t                  in_data;
  logic                  out_valid;
  logic                  out_ready;
  rsp_t                  out_data;

  int   mismatch_count;
  int   results_outstanding;
  int   idle_cycles;
  logic quiet;

  button_debounce_long_press_repeat uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  bdlpr_checker u_check (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_addr            (cfg_addr),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data             (in_data),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_data            (out_data),
    .mismatch_count      (mismatch_count),
    .results_outstanding (results_outstanding)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Mostly short gaps, a few long ones, none in quiet stretches
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet) return 0;
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Offer one request after an optional gap; return at the falling edge after acceptance
  task automatic send_request(input logic kind, input logic pin, input int gap);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid          = 1'b1;
    in_data.req_type  = kind;
    in_data.pin_level = pin;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic tick(input logic pin);
    send_request(REQ_TICK, pin, pick_gap());
  endtask

  task automatic poll();
    send_request(REQ_POLL, 1'($urandom_range(0, 1)), pick_gap());
  endtask

  // Hold the sender until every expected result has come back
  task automatic drain_results();
    in_valid = 1'b0;
    while (results_outstanding != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Write all three registers while the block is idle
  task automatic configure(input logic mode, input logic [HOLD_W-1:0] hold, input logic level);
    drain_results();
    cfg_wr_en = 1'b1;
    cfg_addr  = REG_REPEAT_MODE;
    cfg_wdata = {{(CFG_DATA_W-1){1'b0}}, mode};
    @(negedge clk);
    cfg_addr  = REG_HOLD_TICKS;
    cfg_wdata = hold;
    @(negedge clk);
    cfg_addr  = REG_PRESSED_LEVEL;
    cfg_wdata = {{(CFG_DATA_W-1){1'b0}}, level};
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Press and release episodes with bounce, some noisy runs, polls mixed in
  task automatic run_phase(input logic [HOLD_W-1:0] hold, input logic level, input int count);
    int   run_left;
    int   run_cap;
    logic want_press;
    logic noisy;
    logic pin;
    run_left   = 0;
    want_press = 1'b0;
    noisy      = 1'b0;
    run_cap    = (2 * int'(hold) + 6 > 40) ? 40 : 2 * int'(hold) + 6;
    for (int i = 0; i < count; i++) begin
      if (run_left == 0) begin
        want_press = ~want_press;
        noisy      = ($urandom_range(0, 9) == 0);
        run_left   = $urandom_range(1, run_cap);
      end
      run_left--;
      if ($urandom_range(0, 99) < 15) begin
        poll();
      end else begin
        pin = want_press ? level : ~level;
        if (noisy) begin
          pin = 1'($urandom_range(0, 1));
        end else if ($urandom_range(0, 19) == 0) begin
          pin = ~pin;
        end
        tick(pin);
      end
    end
  endtask

  // Receiver: random stalls on the result channel
  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = pick_gap();
      if (stall != 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus and verdict
  initial begin
    logic              mode;
    logic              level;
    logic [HOLD_W-1:0] hold;
    rst       = 1'b1;
    quiet     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_wr_en = 1'b0;
    cfg_addr  = REG_REPEAT_MODE;
    cfg_wdata = '0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Reset settings: poll empty, press, read and clear, release while held
    poll();
    tick(1'b1);
    repeat (3) tick(1'b0);
    poll();
    poll();
    tick(1'b0);
    tick(1'b1);

    // Hold of one: long press into repeat, release tick still flags
    configure(MODE_LONG_PRESS, 16'd1, 1'b0);
    repeat (3) tick(1'b0);
    tick(1'b0);
    tick(1'b0);
    poll();
    tick(1'b1);
    poll();
    repeat (3) tick(1'b0);
    tick(1'b0);

    // Switch to mode 0 while repeating, hold of zero, pressed level flipped
    configure(MODE_REPEAT_AFTER_HOLD, 16'd0, 1'b1);
    tick(1'b0);
    repeat (3) tick(1'b1);
    tick(1'b1);
    tick(1'b1);
    poll();

    // Random phases across the settings, extremes first
    for (int p = 0; p < PHASES; p++) begin
      mode  = (p < 4) ? p[0] : 1'($urandom_range(0, 1));
      level = (p < 4) ? p[1] : 1'($urandom_range(0, 1));
      case (p)
        0:       hold = 16'hFFFF;
        1:       hold = 16'd0;
        2:       hold = 16'd1;
        7:       hold = HOLD_W'($urandom_range(20, 60));
        default: hold = HOLD_W'($urandom_range(2, 10));
      endcase
      configure(mode, hold, level);
      quiet = (p % 4 == 3);
      run_phase(hold, level, PHASE_ITEMS);
    end
    quiet = 1'b0;

    // Wait for the last results, then settle
    drain_results();
    repeat (4) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
